// ===== src/mws_pkg.sv =====
// ----------------------------------------------------------------------------
// mws_pkg: shared types and constants for the minimum covering window block
// defaults, the front-to-back queue word and the engine state codes
// ----------------------------------------------------------------------------
package mws_pkg;

    localparam int unsigned MAX_TEXT_DEF    = 4096;
    localparam int unsigned MAX_PATTERN_DEF = 4096;
    localparam int unsigned SYM_W           = 8;
    localparam int unsigned SYMS            = 256;

    // classified word handed from the front to the back
    typedef enum logic [1:0] {
        OP_PAT  = 2'd0,
        OP_TEXT = 2'd1,
        OP_DROP = 2'd2
    } op_t;

    typedef struct packed {
        op_t             op;
        logic [SYM_W-1:0] sym;
        logic            last;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PAT_RD,
        ST_PAT_WR,
        ST_TXT_RD,
        ST_TXT_WR,
        ST_SHR_CHK,
        ST_SHR_RD,
        ST_SHR_WR,
        ST_DONE,
        ST_CLEAR
    } st_t;

endpackage

// ===== src/mws_front.sv =====
// ----------------------------------------------------------------------------
// mws_front: input classifier and command queue
// tags each word and buffers it for the window engine
// ----------------------------------------------------------------------------
module mws_front #(
    parameter int unsigned DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_mode,
    input  logic [7:0]       s_symbol,
    input  logic             s_last,
    output logic             q_valid,
    input  logic             q_ready,
    output mws_pkg::cmd_t    q_cmd
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    mws_pkg::cmd_t       fifo_reg [DEPTH];
    logic [AW-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]         cnt_reg;
    mws_pkg::cmd_t       cmd_in;
    logic                push, pop;

    always_comb begin
        cmd_in.sym  = s_symbol;
        cmd_in.last = s_last;
        cmd_in.op   = s_mode ? mws_pkg::OP_TEXT : mws_pkg::OP_PAT;
    end

    assign s_ready = (cnt_reg != (AW+1)'(DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_cmd   = fifo_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

// ===== src/mws_back.sv =====
// ----------------------------------------------------------------------------
// mws_back: sliding window engine
// need table and text buffer in memories, shrink loop one step per pass
// ----------------------------------------------------------------------------
module mws_back #(
    parameter int unsigned MAX_TEXT    = mws_pkg::MAX_TEXT_DEF,
    parameter int unsigned MAX_PATTERN = mws_pkg::MAX_PATTERN_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    output logic          q_ready,
    input  mws_pkg::cmd_t q_cmd,
    output logic          m_valid,
    input  logic          m_ready,
    output logic          m_found,
    output logic [11:0]   m_window_start,
    output logic [12:0]   m_window_length,
    output logic          m_overflow
);
    localparam int unsigned TW = $clog2(MAX_TEXT + 1);
    localparam int unsigned TA = $clog2(MAX_TEXT);
    localparam int unsigned PW = $clog2(MAX_PATTERN + 1);
    localparam int unsigned NW = ((PW > TW) ? PW : TW) + 1;

    logic signed [NW-1:0] need_mem [mws_pkg::SYMS];
    logic [7:0]           text_mem [MAX_TEXT];

    mws_pkg::st_t st_reg, st_next;
    logic [7:0]   sym_reg, sym_next;
    logic         last_reg, last_next;
    logic [PW-1:0] plen_reg, plen_next;
    logic [PW-1:0] match_reg, match_next;
    logic [TW-1:0] left_reg, left_next;
    logic [TW-1:0] right_reg, right_next;
    logic [TW-1:0] bstart_reg, bstart_next;
    logic [TW-1:0] blen_reg, blen_next;
    logic          bnone_reg, bnone_next;
    logic          ovf_reg, ovf_next;
    logic [7:0]    clr_reg, clr_next;
    logic          mv_reg, mv_next;
    logic          of_reg, of_next, oo_reg, oo_next;
    logic [11:0]   os_reg, os_next;
    logic [12:0]   ol_reg, ol_next;

    // memory ports
    logic [7:0]           n_raddr;
    logic signed [NW-1:0] n_rdata_reg;
    logic                 n_we;
    logic [7:0]           n_waddr;
    logic signed [NW-1:0] n_wdata;
    logic [TA-1:0]        t_raddr;
    logic [7:0]           t_rdata_reg;
    logic                 t_we;
    logic [TW-1:0]        wlen;

    always_ff @(posedge aclk) begin
        n_rdata_reg <= need_mem[n_raddr];
        t_rdata_reg <= text_mem[t_raddr];
        if (n_we) begin
            need_mem[n_waddr] <= n_wdata;
        end
        if (t_we) begin
            text_mem[right_reg[TA-1:0]] <= sym_reg;
        end
    end

    assign wlen = right_reg - left_reg;

    always_comb begin
        st_next = st_reg;  sym_next = sym_reg;  last_next = last_reg;
        plen_next = plen_reg;  match_next = match_reg;
        left_next = left_reg;  right_next = right_reg;
        bstart_next = bstart_reg;  blen_next = blen_reg;  bnone_next = bnone_reg;
        ovf_next = ovf_reg;  clr_next = clr_reg;
        mv_next = mv_reg;  of_next = of_reg;  oo_next = oo_reg;
        os_next = os_reg;  ol_next = ol_reg;
        q_ready = 1'b0;
        n_raddr = sym_reg;  n_we = 1'b0;  n_waddr = sym_reg;  n_wdata = n_rdata_reg;
        t_raddr = left_reg[TA-1:0];  t_we = 1'b0;
        if (m_ready) begin
            mv_next = 1'b0;
        end
        unique case (st_reg)
            mws_pkg::ST_IDLE: begin
                q_ready  = 1'b1;
                n_raddr  = q_cmd.sym;
                if (q_valid) begin
                    sym_next  = q_cmd.sym;
                    last_next = q_cmd.last;
                    if (q_cmd.op == mws_pkg::OP_PAT) begin
                        if (right_reg != '0) begin
                            st_next = mws_pkg::ST_IDLE;
                        end else if (plen_reg == PW'(MAX_PATTERN)) begin
                            ovf_next = 1'b1;
                        end else begin
                            st_next = mws_pkg::ST_PAT_WR;
                        end
                    end else if (right_reg == TW'(MAX_TEXT)) begin
                        ovf_next = 1'b1;
                        st_next  = q_cmd.last ? mws_pkg::ST_DONE : mws_pkg::ST_IDLE;
                    end else begin
                        st_next = mws_pkg::ST_TXT_WR;
                    end
                end
            end
            mws_pkg::ST_PAT_WR: begin
                n_we      = 1'b1;
                n_wdata   = n_rdata_reg + NW'(1);
                plen_next = plen_reg + 1'b1;
                st_next   = mws_pkg::ST_IDLE;
            end
            mws_pkg::ST_TXT_WR: begin
                t_we       = 1'b1;
                right_next = right_reg + 1'b1;
                if (plen_reg == '0) begin
                    st_next = last_reg ? mws_pkg::ST_DONE : mws_pkg::ST_IDLE;
                end else begin
                    n_we    = 1'b1;
                    n_wdata = n_rdata_reg - NW'(1);
                    if (n_rdata_reg > 0) begin
                        match_next = match_reg + 1'b1;
                    end
                    st_next = mws_pkg::ST_SHR_CHK;
                end
            end
            mws_pkg::ST_SHR_CHK: begin
                // right_reg now points one past the newest byte
                if (match_reg == plen_reg && left_reg < right_reg) begin
                    if (bnone_reg || wlen < blen_reg) begin
                        bstart_next = left_reg;
                        blen_next   = wlen;
                        bnone_next  = 1'b0;
                    end
                    st_next = mws_pkg::ST_SHR_RD;
                end else begin
                    st_next = last_reg ? mws_pkg::ST_DONE : mws_pkg::ST_IDLE;
                end
            end
            mws_pkg::ST_SHR_RD: begin
                n_raddr = t_rdata_reg;
                sym_next = t_rdata_reg;
                st_next = mws_pkg::ST_SHR_WR;
            end
            mws_pkg::ST_SHR_WR: begin
                n_we    = 1'b1;
                n_wdata = n_rdata_reg + NW'(1);
                if (n_rdata_reg >= 0) begin
                    match_next = match_reg - 1'b1;
                end
                left_next = left_reg + 1'b1;
                t_raddr   = left_next[TA-1:0];
                st_next   = mws_pkg::ST_SHR_CHK;
            end
            mws_pkg::ST_DONE: begin
                if (!mv_reg || m_ready) begin
                    mv_next = 1'b1;
                    of_next = !ovf_reg && !bnone_reg;
                    os_next = of_next ? 12'(bstart_reg) : '0;
                    ol_next = of_next ? 13'(blen_reg) : '0;
                    oo_next = ovf_reg;
                    clr_next = '0;
                    st_next = mws_pkg::ST_CLEAR;
                end
            end
            mws_pkg::ST_CLEAR: begin
                n_we    = 1'b1;
                n_waddr = clr_reg;
                n_wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == 8'hFF) begin
                    plen_next = '0;  match_next = '0;  left_next = '0;
                    right_next = '0; bstart_next = '0; blen_next = '0;
                    bnone_next = 1'b1; ovf_next = 1'b0;
                    st_next = mws_pkg::ST_IDLE;
                end
            end
            default: st_next = mws_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= mws_pkg::ST_CLEAR;
            clr_reg <= '0;
            plen_reg <= '0; match_reg <= '0; left_reg <= '0; right_reg <= '0;
            bstart_reg <= '0; blen_reg <= '0; bnone_reg <= 1'b1; ovf_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            clr_reg <= clr_next;
            plen_reg <= plen_next; match_reg <= match_next;
            left_reg <= left_next; right_reg <= right_next;
            bstart_reg <= bstart_next; blen_reg <= blen_next;
            bnone_reg <= bnone_next; ovf_reg <= ovf_next;
            mv_reg <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        sym_reg <= sym_next; last_reg <= last_next;
        of_reg <= of_next; oo_reg <= oo_next; os_reg <= os_next; ol_reg <= ol_next;
    end

    assign m_valid         = mv_reg;
    assign m_found         = of_reg;
    assign m_window_start  = os_reg;
    assign m_window_length = ol_reg;
    assign m_overflow      = oo_reg;
endmodule

// ===== src/min_window_substring.sv =====
// engine: a pattern word is counted in the need table (PAT_WR); a text word is stored
// (TXT_WR) and checked (SHR_CHK), then each left-edge shrink step runs SHR_RD, SHR_WR, SHR_CHK
// (each byte leaves the window once); the result is registered in ST_DONE, and a clear of all
// 256 need-table entries follows each result and also runs after reset
// reset: synchronous active-low aresetn, clears control state and starts the clear
// a 2-word queue lets the input side keep taking words while the engine works
// ----------------------------------------------------------------------------
// min_window_substring: shortest covering window finder
// streams pattern then text bytes and reports the best covering window
// ----------------------------------------------------------------------------
module min_window_substring #(
    parameter int unsigned MAX_TEXT    = mws_pkg::MAX_TEXT_DEF,
    parameter int unsigned MAX_PATTERN = mws_pkg::MAX_PATTERN_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [7:0]  s_symbol,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_found,
    output logic [11:0] m_window_start,
    output logic [12:0] m_window_length,
    output logic        m_overflow
);
    // queue between the classifier and the engine
    logic          q_valid, q_ready;
    mws_pkg::cmd_t q_cmd;

    mws_front #(.DEPTH(2)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_mode, .s_symbol, .s_last,
        .q_valid, .q_ready, .q_cmd
    );

    // window engine with need table and text buffer
    mws_back #(.MAX_TEXT(MAX_TEXT), .MAX_PATTERN(MAX_PATTERN)) u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_cmd,
        .m_valid, .m_ready, .m_found, .m_window_start, .m_window_length, .m_overflow
    );

    // a found window never comes with overflow
    a_found_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_found && m_overflow)) else $error("found with overflow");

    // no window means zero length
    a_len_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_found) |-> (m_window_length == '0)) else $error("length without window");

    // found window has nonzero length
    a_len_nz: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_found) |-> (m_window_length != '0)) else $error("empty window");
endmodule
